// File: rtl/lcgrm_pkg.sv
// ----------------------------------------------------------------------------
// lcgrm_pkg
// Shared types, command codes and the LCG step for the random modulo core.
// ----------------------------------------------------------------------------
package lcgrm_pkg;

   localparam int unsigned SEED_W = 16;
   localparam int unsigned WORD_W = 32;
   localparam int unsigned ENT_W  = 8;
   localparam int unsigned CMD_W  = 2;
   localparam int unsigned CNT_W  = $clog2(WORD_W);

   localparam logic [CMD_W-1:0] CMD_SHORT = 2'd0;
   localparam logic [CMD_W-1:0] CMD_LONG  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd2;

   localparam logic [WORD_W-1:0] LCG_MUL        = 32'd65531;
   localparam logic [SEED_W-1:0] SEED_HIGH_MASK = 16'hFF00;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_STEP,
      ST_DIV,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic              done;
      logic [WORD_W-1:0] rem;
   } div_stat_type;

   // seed * 65531 + 1, which never exceeds 32 bits
   function automatic logic [WORD_W-1:0] lcg_next(input logic [SEED_W-1:0] seed);
      logic [WORD_W-1:0] prod;
      prod     = {16'd0, seed} * LCG_MUL;
      lcg_next = prod + 32'd1;
   endfunction

   // low byte becomes (3*entropy + low byte) mod 256
   function automatic logic [SEED_W-1:0] mix_seed(input logic [SEED_W-1:0] seed,
                                                  input logic [ENT_W-1:0]  ent);
      logic [ENT_W-1:0] mixed;
      mixed    = seed[ENT_W-1:0] + {ent[ENT_W-2:0], 1'b0} + ent;
      mix_seed = (seed & SEED_HIGH_MASK) | {8'd0, mixed};
   endfunction

endpackage

// File: rtl/lcg_random_modulo_core.sv
// ----------------------------------------------------------------------------
// lcg_random_modulo_core
// 16-bit LCG random source with modular reduction of each draw.
// ----------------------------------------------------------------------------
//  channel   handshake             word
//  req       req_valid/req_stall   req_cmd, req_entropy, req_divisor, req_new_seed
//  rsp       rsp_valid/rsp_stall   rsp_value
//
//  A short draw steps once, a long draw twice, then the bit-serial remainder unit runs;
//  a load or zero-divisor draw goes straight to ST_FINISH.
//  One item is in work at a time; the next is taken while a result waits.
//  Reset clears the seed to zero and empties the result register.
//  A stalled result holds; a finished item waits for the register to free.
// ----------------------------------------------------------------------------
module lcg_random_modulo_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [lcgrm_pkg::CMD_W-1:0]   req_cmd,
   input  logic [lcgrm_pkg::ENT_W-1:0]   req_entropy,
   input  logic [lcgrm_pkg::WORD_W-1:0]  req_divisor,
   input  logic [lcgrm_pkg::SEED_W-1:0]  req_new_seed,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [lcgrm_pkg::WORD_W-1:0]  rsp_value
);
   import lcgrm_pkg::*;

   state_type         state_ff, state_in;
   logic [SEED_W-1:0] seed_ff, seed_in;
   logic [SEED_W-1:0] hi_ff, hi_in;
   logic [WORD_W-1:0] dsr_ff, dsr_in;
   logic              long_ff, long_in;
   logic              second_ff, second_in;
   logic              zero_ff, zero_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0] rsp_value_ff, rsp_value_in;

   logic              accept;
   logic              draw_ok;
   logic              out_free;
   logic              div_start;
   logic              finish_write;
   logic [WORD_W-1:0] v;
   logic [WORD_W-1:0] div_dividend;
   div_stat_type      div_stat;

   assign v        = lcg_next(seed_ff);
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign accept   = req_valid && !req_stall;

   always_comb begin
      draw_ok = 1'b0;
      unique case (req_cmd)
         CMD_SHORT: draw_ok = (req_divisor[SEED_W-1:0] != '0);
         CMD_LONG:  draw_ok = (req_divisor != '0);
         default:   draw_ok = 1'b0;
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (req_valid) state_in = draw_ok ? ST_STEP : ST_FINISH;
         ST_STEP:   if (!long_ff || second_ff) state_in = ST_DIV;
         ST_DIV:    if (div_stat.done) state_in = ST_FINISH;
         ST_FINISH: if (out_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_stall    = (state_ff != ST_IDLE);
      div_start    = (state_ff == ST_STEP) && (!long_ff || second_ff);
      finish_write = (state_ff == ST_FINISH) && out_free;
   end

   assign div_dividend = long_ff ? {hi_ff, v[SEED_W-1:0]} : v;

   always_comb begin
      seed_in   = seed_ff;
      hi_in     = hi_ff;
      dsr_in    = dsr_ff;
      long_in   = long_ff;
      second_in = second_ff;
      zero_in   = zero_ff;
      if (accept) begin
         long_in   = (req_cmd == CMD_LONG);
         second_in = 1'b0;
         zero_in   = !draw_ok;
         dsr_in    = (req_cmd == CMD_SHORT) ? {16'd0, req_divisor[SEED_W-1:0]}
                                            : req_divisor;
         if (draw_ok) seed_in = mix_seed(seed_ff, req_entropy);
         else if (req_cmd == CMD_LOAD) seed_in = req_new_seed;
      end
      if (state_ff == ST_STEP) begin
         // advance the seed; the first long step supplies the high half
         seed_in   = v[SEED_W-1:0];
         hi_in     = v[SEED_W-1:0];
         second_in = 1'b1;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_value_in = rsp_value_ff;
      if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;
      if (finish_write) begin
         rsp_valid_in = 1'b1;
         rsp_value_in = zero_ff ? '0 : div_stat.rem;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         seed_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         seed_ff      <= seed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      hi_ff        <= hi_in;
      dsr_ff       <= dsr_in;
      long_ff      <= long_in;
      second_ff    <= second_in;
      zero_ff      <= zero_in;
      rsp_value_ff <= rsp_value_in;
   end

   lcgrm_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (dsr_ff),
      .stat     (div_stat)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_value = rsp_value_ff;

endmodule

// File: rtl/lcgrm_div.sv
// ----------------------------------------------------------------------------
// lcgrm_div
// Bit-serial restoring remainder unit: one dividend bit per cycle.
// ----------------------------------------------------------------------------
module lcgrm_div (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [lcgrm_pkg::WORD_W-1:0]   dividend,
   input  logic [lcgrm_pkg::WORD_W-1:0]   divisor,
   output lcgrm_pkg::div_stat_type        stat
);
   import lcgrm_pkg::*;

   logic [WORD_W-1:0] rem_ff,  rem_in;
   logic [WORD_W-1:0] dvd_ff,  dvd_in;
   logic [WORD_W-1:0] dsr_ff,  dsr_in;
   logic [CNT_W-1:0]  cnt_ff,  cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;

   logic [WORD_W:0]   trial;
   logic [WORD_W+1:0] diff;

   always_comb begin
      trial   = {rem_ff, dvd_ff[WORD_W-1]};
      diff    = {1'b0, trial} - {2'b00, dsr_ff};
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         dvd_in  = dividend;
         dsr_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // keep the difference unless it borrowed
         rem_in = diff[WORD_W+1] ? trial[WORD_W-1:0] : diff[WORD_W-1:0];
         dvd_in = {dvd_ff[WORD_W-2:0], 1'b0};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(WORD_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      dsr_ff <= dsr_in;
   end

   assign stat.done = done_ff;
   assign stat.rem  = rem_ff;

endmodule
